### design/gbaqp_pkg.sv
// ----------------------------------------------------------------------------
// gbaqp_pkg: shared types and constants for the GOP bit allocation core
// Field widths, register indexes, frame type codes and the command and
// status words that join the controller and the datapath.
// ----------------------------------------------------------------------------
package gbaqp_pkg;

  localparam int MAX_FRAMES_DEF = 16;

  localparam int BR_W       = 27;
  localparam int FR_W       = 8;
  localparam int QP_W       = 6;
  localparam int TW_W       = 8;
  localparam int FT_W       = 2;
  localparam int CPLX_W     = 12;
  localparam int W_W        = 20;
  localparam int TOT_W      = 24;
  localparam int IDX_OUT_W  = 4;
  localparam int BITS_W     = 31;
  localparam int QPO_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;
  localparam int DEN_W      = 32;
  localparam int LOG_FRAC   = 20;
  localparam int LOG_W      = 25;
  localparam int MANT_W     = 31;
  localparam int K_W        = 5;
  localparam int V_W        = 40;

  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};
  localparam int QP_MAX = 2047;
  localparam int QP_MIN = -1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BITRATE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_QP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_W_INTRA    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W_PRED     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_W_BIDIR    = 3'd5;

  // Frame type codes
  localparam logic [FT_W-1:0] FT_INTRA = 2'd0;
  localparam logic [FT_W-1:0] FT_PRED  = 2'd1;
  localparam logic [FT_W-1:0] FT_BIDIR = 2'd2;

  typedef struct packed {
    logic load;
    logic rd;
    logic mul1;
    logic mul2;
    logic div_go;
    logic log_go;
    logic log_sel_t;
    logic cap_lx;
    logic cap_lt;
    logic emit;
    logic idx_inc;
    logic clear;
  } gbaqp_cmd_t;

  typedef struct packed {
    logic zero_w;
    logic last_idx;
    logic log_done;
    logic div_done;
  } gbaqp_stat_t;

endpackage

### design/gbaqp_div.sv
// ----------------------------------------------------------------------------
// gbaqp_div: restoring divider, one quotient bit per cycle
// Produces NUM_W quotient bits after go; done stays high while idle.
// ----------------------------------------------------------------------------
module gbaqp_div #(
  parameter int NUM_W = 54
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [NUM_W-1:0]               num,
  input  logic [gbaqp_pkg::DEN_W-1:0]    den,
  output logic [NUM_W-1:0]               quo,
  output logic                           done
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int D_W   = gbaqp_pkg::DEN_W;

  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [D_W:0]     r2;
  logic             fits;

  assign r2   = {rem, quo[NUM_W-1]};
  assign fits = (r2 >= {1'b0, den});
  assign done = (cnt == '0);

  // Control: step count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (go) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Shift in one quotient bit per step
  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= num;
    end else if (cnt != '0) begin
      if (fits) begin
        rem <= D_W'(r2 - {1'b0, den});
      end else begin
        rem <= r2[D_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

### design/gbaqp_log2.sv
// ----------------------------------------------------------------------------
// gbaqp_log2: fixed-point log2 by normalization and repeated squaring
// Shifts the mantissa up one bit per cycle, then squares once per cycle
// for each of the LOG_FRAC fraction bits.
// ----------------------------------------------------------------------------
module gbaqp_log2 #(
  parameter int X_W = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [X_W-1:0]                x,
  output logic [gbaqp_pkg::LOG_W-1:0]   res,
  output logic                          done
);

  localparam int M_W  = gbaqp_pkg::MANT_W;
  localparam int K_W  = gbaqp_pkg::K_W;
  localparam int FR   = gbaqp_pkg::LOG_FRAC;
  localparam int FC_W = $clog2(FR);

  localparam logic [1:0] PH_DONE = 2'd0;
  localparam logic [1:0] PH_NORM = 2'd1;
  localparam logic [1:0] PH_SQ   = 2'd2;

  logic [1:0]       phase;
  logic [M_W-1:0]   m;
  logic [K_W-1:0]   k;
  logic [FC_W-1:0]  cnt;
  logic [2*M_W-1:0] sq;
  logic [M_W:0]     s;

  assign sq   = (2*M_W)'(m) * (2*M_W)'(m);
  assign s    = sq[2*M_W-1:M_W-1];
  assign done = (phase == PH_DONE);

  // Phase control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DONE;
    end else begin
      case (phase)
        PH_DONE: if (go) phase <= PH_NORM;
        PH_NORM: if (m[M_W-1]) phase <= PH_SQ;
        PH_SQ:   if (cnt == '0) phase <= PH_DONE;
        default: phase <= PH_DONE;
      endcase
    end
  end

  // Normalize, then square once per fraction bit
  always_ff @(posedge clk) begin
    case (phase)
      PH_DONE: begin
        if (go) begin
          m <= M_W'(x);
          k <= K_W'(M_W - 1);
        end
      end
      PH_NORM: begin
        if (m[M_W-1]) begin
          res <= gbaqp_pkg::LOG_W'(k) << FR;
          cnt <= FC_W'(FR - 1);
        end else begin
          m <= {m[M_W-2:0], 1'b0};
          k <= k - K_W'(1);
        end
      end
      PH_SQ: begin
        if (s[M_W]) begin
          m   <= s[M_W:1];
          res <= res | (gbaqp_pkg::LOG_W'(1) << cnt);
        end else begin
          m <= s[M_W-1:0];
        end
        cnt <= cnt - FC_W'(1);
      end
      default: ;
    endcase
  end

endmodule

### design/gbaqp_dp.sv
// ----------------------------------------------------------------------------
// gbaqp_dp: datapath of the GOP bit allocation core
// Holds configuration, the weight store and group sums, the multiply
// stages, the divider and the log2 unit, and forms the result word.
// ----------------------------------------------------------------------------
module gbaqp_dp #(
  parameter int MAX_FRAMES = gbaqp_pkg::MAX_FRAMES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gbaqp_pkg::gbaqp_cmd_t               cmd,
  output gbaqp_pkg::gbaqp_stat_t              stat,
  input  logic [gbaqp_pkg::FT_W-1:0]          frame_type,
  input  logic [gbaqp_pkg::CPLX_W-1:0]        complexity_q48,
  input  logic                                cfg_wr,
  input  logic [gbaqp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gbaqp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [gbaqp_pkg::IDX_OUT_W-1:0]     frame_index,
  output logic [gbaqp_pkg::BITS_W-1:0]        allocated_bits,
  output logic signed [gbaqp_pkg::QPO_W-1:0]  qp_q4,
  output logic                                last_result
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int W_W   = gbaqp_pkg::W_W;
  localparam int TOT_W = gbaqp_pkg::TOT_W;
  localparam int XW    = CNT_W + W_W;
  localparam int LX_W  = (XW > TOT_W) ? XW : TOT_W;
  localparam int NUM_W = gbaqp_pkg::BR_W + XW;
  localparam int LOG_W = gbaqp_pkg::LOG_W;
  localparam int V_W   = gbaqp_pkg::V_W;
  localparam int FR    = gbaqp_pkg::LOG_FRAC;

  // Configuration registers
  logic [gbaqp_pkg::BR_W-1:0] bitrate;
  logic [gbaqp_pkg::FR_W-1:0] frame_rate;
  logic [gbaqp_pkg::QP_W-1:0] reference_qp;
  logic [gbaqp_pkg::TW_W-1:0] weight_intra;
  logic [gbaqp_pkg::TW_W-1:0] weight_predicted;
  logic [gbaqp_pkg::TW_W-1:0] weight_bidir;

  // Group state
  logic [W_W-1:0]   weight_store [MAX_FRAMES];
  logic [TOT_W-1:0] weight_total;
  logic [CNT_W-1:0] frame_count;
  logic [IDX_W-1:0] idx;

  // Per-frame work registers
  logic [W_W-1:0]                   wi;
  logic [XW-1:0]                    cw;
  logic [gbaqp_pkg::DEN_W-1:0]      den;
  logic [NUM_W-1:0]                 num;
  logic [LOG_W-1:0]                 lx;
  logic [LOG_W-1:0]                 lt;

  logic [gbaqp_pkg::TW_W-1:0]  tw;
  logic [W_W-1:0]              w_new;
  logic [TOT_W:0]              sum_new;
  logic                        room;
  logic [gbaqp_pkg::FR_W-1:0]  fps;
  logic [NUM_W-1:0]            quo;
  logic                        div_done;
  logic [LX_W-1:0]             log_x;
  logic [LOG_W-1:0]            log_res;
  logic                        log_done;
  logic                        zero_w;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      bitrate          <= gbaqp_pkg::BR_W'(4000000);
      frame_rate       <= gbaqp_pkg::FR_W'(30);
      reference_qp     <= gbaqp_pkg::QP_W'(28);
      weight_intra     <= gbaqp_pkg::TW_W'(20);
      weight_predicted <= gbaqp_pkg::TW_W'(4);
      weight_bidir     <= gbaqp_pkg::TW_W'(1);
    end else if (cfg_wr) begin
      case (cfg_index)
        gbaqp_pkg::REG_BITRATE:    bitrate <= cfg_data;
        gbaqp_pkg::REG_FRAME_RATE: frame_rate <= cfg_data[gbaqp_pkg::FR_W-1:0];
        gbaqp_pkg::REG_REF_QP:     reference_qp <= cfg_data[gbaqp_pkg::QP_W-1:0];
        gbaqp_pkg::REG_W_INTRA:    weight_intra <= cfg_data[gbaqp_pkg::TW_W-1:0];
        gbaqp_pkg::REG_W_PRED:     weight_predicted <= cfg_data[gbaqp_pkg::TW_W-1:0];
        gbaqp_pkg::REG_W_BIDIR:    weight_bidir <= cfg_data[gbaqp_pkg::TW_W-1:0];
        default: ;
      endcase
    end
  end

  // Select the type weight and form the frame weight
  always_comb begin
    case (frame_type)
      gbaqp_pkg::FT_INTRA: tw = weight_intra;
      gbaqp_pkg::FT_PRED:  tw = weight_predicted;
      gbaqp_pkg::FT_BIDIR: tw = weight_bidir;
      default:             tw = gbaqp_pkg::TW_W'(1);
    endcase
  end

  assign w_new   = W_W'(tw) * W_W'(complexity_q48);
  assign sum_new = {1'b0, weight_total} + (TOT_W+1)'(w_new);
  assign room    = (frame_count < CNT_W'(MAX_FRAMES));
  assign fps     = (frame_rate == '0) ? gbaqp_pkg::FR_W'(1) : frame_rate;

  // Count frames and sum weights, saturating the sum
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_total <= '0;
      frame_count  <= '0;
      idx          <= '0;
    end else if (cmd.clear) begin
      weight_total <= '0;
      frame_count  <= '0;
      idx          <= '0;
    end else begin
      if (cmd.load && room) begin
        frame_count  <= frame_count + CNT_W'(1);
        weight_total <= sum_new[TOT_W] ? gbaqp_pkg::TOTAL_MAX : sum_new[TOT_W-1:0];
      end
      if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // Weight store: write on load, registered read
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      weight_store[frame_count[IDX_W-1:0]] <= w_new;
    end
    if (cmd.rd) begin
      wi <= weight_store[idx];
    end
  end

  // Multiply stages, each registered
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      cw  <= XW'(frame_count) * XW'(wi);
      den <= gbaqp_pkg::DEN_W'(fps) * gbaqp_pkg::DEN_W'(weight_total);
    end
    if (cmd.mul2) begin
      num <= NUM_W'(bitrate) * NUM_W'(cw);
    end
    if (cmd.cap_lx) begin
      lx <= log_res;
    end
    if (cmd.cap_lt) begin
      lt <= log_res;
    end
  end

  assign log_x = cmd.log_sel_t ? LX_W'(weight_total) : LX_W'(cw);

  gbaqp_div #(.NUM_W(NUM_W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_go),
    .num  (num),
    .den  (den),
    .quo  (quo),
    .done (div_done)
  );

  gbaqp_log2 #(.X_W(LX_W)) u_log2 (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.log_go),
    .x    (log_x),
    .res  (log_res),
    .done (log_done)
  );

  assign zero_w = (wi == '0) || (weight_total == '0);

  assign stat.zero_w   = zero_w;
  assign stat.last_idx = ((CNT_W+1)'(idx) + (CNT_W+1)'(1)) == (CNT_W+1)'(frame_count);
  assign stat.log_done = log_done;
  assign stat.div_done = div_done;

  // Form the QP from the log difference, rounded and saturated
  logic signed [LOG_W:0]   d;
  logic signed [V_W-1:0]   v;
  logic [V_W-FR-1:0]       t;
  logic signed [V_W-FR:0]  q;
  logic signed [gbaqp_pkg::QPO_W-1:0] qp_sat;

  always_comb begin
    d = $signed({1'b0, lx}) - $signed({1'b0, lt});
    v = ($signed(V_W'(reference_qp)) <<< (FR + 4))
        - V_W'(d) * $signed(V_W'(96))
        + $signed(V_W'(1) << (FR - 1))
        + ($signed(V_W'(4096)) <<< FR);
    t = (v < 0) ? '0 : v[V_W-1:FR];
    q = $signed({1'b0, t}) - $signed((V_W-FR+1)'(4096));
    if (q > $signed((V_W-FR+1)'(gbaqp_pkg::QP_MAX))) begin
      qp_sat = gbaqp_pkg::QPO_W'(gbaqp_pkg::QP_MAX);
    end else if (q < $signed((V_W-FR+1)'(gbaqp_pkg::QP_MIN))) begin
      qp_sat = gbaqp_pkg::QPO_W'(gbaqp_pkg::QP_MIN);
    end else begin
      qp_sat = q[gbaqp_pkg::QPO_W-1:0];
    end
  end

  // Result word
  assign frame_index    = gbaqp_pkg::IDX_OUT_W'(idx);
  assign allocated_bits = zero_w ? '0 :
                          (quo[NUM_W-1:gbaqp_pkg::BITS_W] != '0) ? {gbaqp_pkg::BITS_W{1'b1}} :
                          quo[gbaqp_pkg::BITS_W-1:0];
  assign qp_q4          = zero_w ? gbaqp_pkg::QPO_W'(gbaqp_pkg::QP_MAX) : qp_sat;
  assign last_result    = stat.last_idx;

endmodule

### design/gbaqp_ctrl.sv
// ----------------------------------------------------------------------------
// gbaqp_ctrl: sequencer of the GOP bit allocation core
// Takes frames while idle; on the last frame walks the stored group and
// runs the multiply, divide and log2 steps for each entry of nonzero weight.
// ----------------------------------------------------------------------------
module gbaqp_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    last_frame,
  input  gbaqp_pkg::gbaqp_stat_t  stat,
  output gbaqp_pkg::gbaqp_cmd_t   cmd,
  output logic                    busy,
  output logic                    done
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_XGO   = 4'd4;
  localparam logic [3:0] S_XWAIT = 4'd5;
  localparam logic [3:0] S_TGO   = 4'd6;
  localparam logic [3:0] S_TWAIT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_frame) state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = stat.zero_w ? S_OUT : S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_XGO;
      end
      S_XGO: begin
        cmd.div_go = 1'b1;
        cmd.log_go = 1'b1;
        state_next = S_XWAIT;
      end
      S_XWAIT: begin
        if (stat.log_done) begin
          cmd.cap_lx = 1'b1;
          state_next = S_TGO;
        end
      end
      S_TGO: begin
        cmd.log_go    = 1'b1;
        cmd.log_sel_t = 1'b1;
        state_next    = S_TWAIT;
      end
      S_TWAIT: begin
        cmd.log_sel_t = 1'b1;
        if (stat.log_done && stat.div_done) begin
          cmd.cap_lt = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        cmd.emit = 1'b1;
        if (stat.last_idx) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = cmd.emit;

endmodule

### design/gop_bit_allocation_qp_core.sv
// ----------------------------------------------------------------------------
// gop_bit_allocation_qp_core: GOP weighted bit allocation with QP derivation
// A frame is loaded while idle when start is high; busy stays low between frames.
// After the last frame, each stored frame is taken in turn through two log2
// passes, each a normalize, one squaring per fraction bit and a capture;
// the 52-step divider runs beside them, and the second capture also waits
// for it. Zero weights skip the divide and log2 steps.
// One result word per strobe cycle; the receiver cannot stall.
// Synchronous reset clears the group and loads register defaults.
// ----------------------------------------------------------------------------
module gop_bit_allocation_qp_core #(
  parameter int MAX_FRAMES = gbaqp_pkg::MAX_FRAMES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [gbaqp_pkg::FT_W-1:0]          frame_type,
  input  logic [gbaqp_pkg::CPLX_W-1:0]        complexity_q48,
  input  logic                                last_frame,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gbaqp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gbaqp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                done,
  output logic [gbaqp_pkg::IDX_OUT_W-1:0]     frame_index,
  output logic [gbaqp_pkg::BITS_W-1:0]        allocated_bits,
  output logic signed [gbaqp_pkg::QPO_W-1:0]  qp_q4,
  output logic                                last_result
);

  gbaqp_pkg::gbaqp_cmd_t  cmd;
  gbaqp_pkg::gbaqp_stat_t stat;

  // Configuration words are always taken
  assign cfg_ready = 1'b1;

  gbaqp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_frame (last_frame),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .done       (done)
  );

  gbaqp_dp #(.MAX_FRAMES(MAX_FRAMES)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .frame_type     (frame_type),
    .complexity_q48 (complexity_q48),
    .cfg_wr         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .frame_index    (frame_index),
    .allocated_bits (allocated_bits),
    .qp_q4          (qp_q4),
    .last_result    (last_result)
  );

endmodule
